/* rtl/mmlr_pkg.sv */
// shared types, widths and codes for the multi-mode line rasterizer
// no dependencies; imported by every module of the block
`default_nettype none
package mmlr_pkg;

	// coordinate, fraction and colour widths
	localparam int CW = 16;
	localparam int FB = 16;
	localparam int COLW = 24;

	// derived widths
	localparam int DW = CW + 1;          // signed endpoint difference
	localparam int IW = CW + 1;          // pixel index, can reach steps + 1
	localparam int AW = CW + FB + 1;     // dda accumulator
	localparam int INCW = FB + 2;        // dda increment
	localparam int DECW = CW + 3;        // midpoint decision variable
	localparam int NW = 2 * CW + 2;      // parametric numerator
	localparam int DVN = (CW + FB > NW) ? CW + FB : NW;   // divider dividend
	localparam int DVD = CW + 1;         // divider divisor
	localparam int DCNTW = $clog2(DVN + 1);

	// stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = ((4 * CW + COLW + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * CW + COLW + 7) / 8) * 8;

	// configuration port
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_MODE = 2'd0;

	// algorithm codes of the mode register
	localparam logic [1:0] MODE_DDA = 2'd0;
	localparam logic [1:0] MODE_MIDPOINT = 2'd1;
	localparam logic [1:0] MODE_PARAMETRIC = 2'd2;

	// operation codes of an input transaction
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	// decoded command between front and back
	typedef struct packed {
		logic                   is_load;
		logic signed [CW-1:0]   x1;
		logic signed [CW-1:0]   y1;
		logic signed [DW-1:0]   dx;
		logic signed [DW-1:0]   dy;
		logic [CW-1:0]          ax;
		logic [CW-1:0]          ay;
		logic [COLW-1:0]        colour;
	} item_t;

	// one emitted pixel
	typedef struct packed {
		logic                   last;
		logic [COLW-1:0]        colour;
		logic [CW-1:0]          py;
		logic [CW-1:0]          px;
	} pix_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// back-end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_PMX,
		ST_PMY,
		ST_PX_GO,
		ST_PX_WAIT,
		ST_PY_GO,
		ST_PY_WAIT,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

/* rtl/multi_mode_line_rasterizer_top.sv */
// Load: DDA runs two serial divides (DVN = 34); parametric forms two start products; midpoint sets up on the pop.
// Pixel: DDA or midpoint goes from queue head through the pixel register and the output register to
// m_tvalid; parametric first makes two passes through the one-bit-per-cycle divider.
// Items are handled one at a time by the back end; a two-entry queue takes further items while it
// works and drops s_tready when full. Reset (arst_n low, asynchronous) clears the queue, ends any
// line and sets mode to midpoint.
// top level: configuration register and stream ports; uses mmlr_pkg and all mmlr modules
`default_nettype none
module multi_mode_line_rasterizer_top import mmlr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// x_start, y_start, x_end, y_end, colour_in, zero padding
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// op
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// pixel_x, pixel_y, colour_out, zero padding
	output logic [M_TDATA_W-1:0]      m_tdata,
	output logic                      m_tlast
);

	logic [1:0]     mode_q;
	logic           q_valid;
	item_t          q_item;
	logic           q_pop;
	logic           div_start;
	logic [DVN-1:0] div_num;
	logic [DVD-1:0] div_den;
	div_stat_t      div_stat;
	logic [DVN-1:0] div_quo;
	pix_t           out_pix;

	// mode register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MIDPOINT;
		end else if (psel && penable && pwrite && paddr == ADDR_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end
	assign prdata = (paddr == ADDR_MODE) ? {30'd0, mode_q} : 32'd0;

	mmlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	mmlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	mmlr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.div_start (div_start),
		.div_num   (div_num),
		.div_den   (div_den),
		.div_stat  (div_stat),
		.div_quo   (div_quo),
		.out_valid (m_tvalid),
		.out_pix   (out_pix),
		.out_ready (m_tready)
	);

	// pack the result
	assign m_tdata = M_TDATA_W'({out_pix.colour, out_pix.py, out_pix.px});
	assign m_tlast = out_pix.last;

endmodule
`default_nettype wire

/* rtl/mmlr_front.sv */
// front end: accepts input transactions, decodes them and queues them
// depends on mmlr_pkg
`default_nettype none
module mmlr_front import mmlr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// x_start, y_start, x_end, y_end, colour_in, zero padding
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// op
	input  wire logic                 s_tuser,
	output logic                      q_valid,
	output item_t                     q_item,
	input  wire logic                 q_pop
);

	item_t           mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	item_t           dec;
	logic            push;
	logic signed [CW-1:0] xs, ys, xe, ye;

	// decode fields and endpoint differences
	always_comb begin
		xs = s_tdata[CW-1:0];
		ys = s_tdata[2*CW-1:CW];
		xe = s_tdata[3*CW-1:2*CW];
		ye = s_tdata[4*CW-1:3*CW];
		dec.is_load = (s_tuser == OP_LOAD);
		dec.x1 = xs;
		dec.y1 = ys;
		dec.dx = DW'(xe) - DW'(xs);
		dec.dy = DW'(ye) - DW'(ys);
		dec.ax = dec.dx[DW-1] ? CW'(-dec.dx) : dec.dx[CW-1:0];
		dec.ay = dec.dy[DW-1] ? CW'(-dec.dy) : dec.dy[CW-1:0];
		dec.colour = s_tdata[4*CW+COLW-1:4*CW];
	end

	assign s_tready = (count_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (count_q != 2'd0);
	assign q_item = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

/* rtl/mmlr_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on mmlr_pkg
`default_nettype none
module mmlr_div import mmlr_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DVN-1:0] num,
	input  wire logic [DVD-1:0] den,
	output div_stat_t           stat,
	output logic [DVN-1:0]      quo
);

	logic             busy_q;
	logic             done_q;
	logic [DCNTW-1:0] cnt_q;
	logic [DVD:0]     rem_q;
	logic [DVN-1:0]   quo_q;
	logic [DVD-1:0]   den_q;
	logic [DVD:0]     trial;
	logic             fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q[DVD-1:0], quo_q[DVN-1]};
	assign fits = (trial >= {1'b0, den_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= DCNTW'(DVN);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[DVN-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = quo_q;

endmodule
`default_nettype wire

/* rtl/mmlr_back.sv */
// back end: line setup and pixel walk for dda, midpoint and parametric modes
// depends on mmlr_pkg; drives the shared mmlr_div through its ports
`default_nettype none
module mmlr_back import mmlr_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     mode,
	input  wire logic           q_valid,
	input  wire item_t          q_item,
	output logic                q_pop,
	output logic                div_start,
	output logic [DVN-1:0]      div_num,
	output logic [DVD-1:0]      div_den,
	input  wire div_stat_t      div_stat,
	input  wire logic [DVN-1:0] div_quo,
	output logic                out_valid,
	output pix_t                out_pix,
	input  wire logic           out_ready
);

	state_t state_q, state_d;

	// line state
	logic                   active_q;
	logic [1:0]             line_mode_q;
	logic signed [CW-1:0]   origin_x_q, origin_y_q;
	logic signed [DW-1:0]   dx_q, dy_q;
	logic [CW-1:0]          ax_q, ay_q;
	logic [CW-1:0]          steps_q;
	logic [IW-1:0]          index_q;
	logic [CW-1:0]          cur_x_q, cur_y_q;
	logic signed [DECW-1:0] decision_q;
	logic                   x_major_q;
	logic signed [AW-1:0]   acc_x_q, acc_y_q;
	logic signed [INCW-1:0] inc_x_q, inc_y_q;
	logic signed [NW-1:0]   num_x_q, num_y_q;
	logic [COLW-1:0]        colour_q;

	// pixel being built and output register
	logic [CW-1:0]          px_q, py_q;
	logic                   last_q;
	logic                   out_valid_q;
	pix_t                   out_q;

	// decoded helpers
	logic                   ld_x_major;
	logic [CW-1:0]          ld_steps;
	logic                   steps_zero;
	logic                   fin;
	logic                   emit;
	logic signed [2*CW:0]   prod;
	logic signed [CW-1:0]   mul_a;
	logic signed [NW-1:0]   num_sel;
	logic [NW-1:0]          num_mag;
	logic [CW-1:0]          fr_x, fr_y;
	logic [CW-1:0]          div_pix;
	logic signed [INCW-1:0] div_inc;
	logic                   div_neg;

	assign ld_x_major = (q_item.ax >= q_item.ay);
	assign ld_steps = ld_x_major ? q_item.ax : q_item.ay;
	assign steps_zero = (steps_q == '0);
	assign fin = (index_q >= IW'(steps_q));

	// round an accumulator to the nearest pixel, halves away from zero
	function automatic logic [CW-1:0] fix_round(input logic signed [AW-1:0] acc);
		logic [AW-1:0] m;
		logic [AW-1:0] r;
		m = acc[AW-1] ? AW'(-acc) : AW'(acc);
		r = (m + (AW'(1) << (FB - 1))) >> FB;
		return acc[AW-1] ? CW'(-r) : r[CW-1:0];
	endfunction

	assign fr_x = fix_round(acc_x_q);
	assign fr_y = fix_round(acc_y_q);

	// parametric start term origin * steps
	assign mul_a = (state_q == ST_PMY) ? origin_y_q : origin_x_q;
	assign prod = mul_a * $signed({1'b0, steps_q});

	// divider operand select
	assign num_sel = (state_q == ST_PY_GO) ? num_y_q : num_x_q;
	assign num_mag = num_sel[NW-1] ? NW'(-num_sel) : NW'(num_sel);

	// sign of the value being divided, for the result
	always_comb begin
		unique case (state_q)
			ST_DX_WAIT: div_neg = dx_q[DW-1];
			ST_DY_WAIT: div_neg = dy_q[DW-1];
			ST_PX_WAIT: div_neg = num_x_q[NW-1];
			ST_PY_WAIT: div_neg = num_y_q[NW-1];
			default:    div_neg = 1'b0;
		endcase
	end
	assign div_inc = div_neg ? INCW'(-div_quo[INCW-1:0]) : div_quo[INCW-1:0];
	assign div_pix = div_neg ? CW'(-div_quo[CW-1:0]) : div_quo[CW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.is_load) begin
						if (mode == MODE_DDA && ld_steps != '0) state_d = ST_DX_GO;
						else if (mode == MODE_PARAMETRIC && ld_steps != '0) state_d = ST_PMX;
					end else if (active_q) begin
						if (line_mode_q == MODE_PARAMETRIC && !steps_zero) state_d = ST_PX_GO;
						else state_d = ST_EMIT;
					end
				end
			end
			ST_DX_GO:   state_d = ST_DX_WAIT;
			ST_DX_WAIT: if (div_stat.done) state_d = ST_DY_GO;
			ST_DY_GO:   state_d = ST_DY_WAIT;
			ST_DY_WAIT: if (div_stat.done) state_d = ST_IDLE;
			ST_PMX:     state_d = ST_PMY;
			ST_PMY:     state_d = ST_IDLE;
			ST_PX_GO:   state_d = ST_PX_WAIT;
			ST_PX_WAIT: if (div_stat.done) state_d = ST_PY_GO;
			ST_PY_GO:   state_d = ST_PY_WAIT;
			ST_PY_WAIT: if (div_stat.done) state_d = ST_EMIT;
			ST_EMIT:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop = 1'b0;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		emit = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_DX_GO: begin
				div_start = 1'b1;
				div_num = DVN'({ax_q, {FB{1'b0}}});
				div_den = DVD'(steps_q);
			end
			ST_DY_GO: begin
				div_start = 1'b1;
				div_num = DVN'({ay_q, {FB{1'b0}}});
				div_den = DVD'(steps_q);
			end
			ST_PX_GO, ST_PY_GO: begin
				div_start = 1'b1;
				div_num = DVN'({num_mag[NW-2:0], 1'b0} + NW'(steps_q));
				div_den = {steps_q, 1'b0};
			end
			ST_EMIT: emit = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			line_mode_q <= MODE_MIDPOINT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				if (q_item.is_load) begin
					active_q <= (mode != 2'd3);
					line_mode_q <= mode;
				end else if (active_q && fin) begin
					active_q <= 1'b0;
				end
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// line datapath
	always_ff @(posedge clk) begin
		if (q_pop && q_item.is_load) begin
			// line setup
			origin_x_q <= q_item.x1;
			origin_y_q <= q_item.y1;
			dx_q <= q_item.dx;
			dy_q <= q_item.dy;
			ax_q <= q_item.ax;
			ay_q <= q_item.ay;
			steps_q <= ld_steps;
			index_q <= '0;
			colour_q <= q_item.colour;
			cur_x_q <= q_item.x1;
			cur_y_q <= q_item.y1;
			x_major_q <= ld_x_major;
			decision_q <= ld_x_major
				? (DECW'({q_item.ay, 1'b0}) - DECW'(q_item.ax))
				: (DECW'({q_item.ax, 1'b0}) - DECW'(q_item.ay));
			acc_x_q <= {q_item.x1[CW-1], q_item.x1, {FB{1'b0}}};
			acc_y_q <= {q_item.y1[CW-1], q_item.y1, {FB{1'b0}}};
			inc_x_q <= '0;
			inc_y_q <= '0;
		end else if (q_pop && active_q) begin
			// one pixel step
			index_q <= index_q + 1'b1;
			last_q <= fin;
			unique case (line_mode_q)
				MODE_DDA: begin
					px_q <= fr_x;
					py_q <= fr_y;
					acc_x_q <= acc_x_q + AW'(inc_x_q);
					acc_y_q <= acc_y_q + AW'(inc_y_q);
				end
				MODE_MIDPOINT: begin
					px_q <= cur_x_q;
					py_q <= cur_y_q;
					if (x_major_q) begin
						if (decision_q > 0) begin
							cur_y_q <= cur_y_q + ((dy_q > 0) ? CW'(1) : '1);
							decision_q <= decision_q
								+ DECW'($signed({(DW'(ay_q) - DW'(ax_q)), 1'b0}));
						end else begin
							decision_q <= decision_q + DECW'({ay_q, 1'b0});
						end
						cur_x_q <= cur_x_q + ((dx_q > 0) ? CW'(1) : '1);
					end else begin
						if (decision_q > 0) begin
							cur_x_q <= cur_x_q + ((dx_q > 0) ? CW'(1) : '1);
							decision_q <= decision_q
								+ DECW'($signed({(DW'(ax_q) - DW'(ay_q)), 1'b0}));
						end else begin
							decision_q <= decision_q + DECW'({ax_q, 1'b0});
						end
						cur_y_q <= cur_y_q + ((dy_q > 0) ? CW'(1) : '1);
					end
				end
				default: begin
					// parametric; a zero-length line shows its start point
					px_q <= origin_x_q;
					py_q <= origin_y_q;
				end
			endcase
		end

		// dda increments and parametric terms
		unique case (state_q)
			ST_DX_WAIT: if (div_stat.done) inc_x_q <= div_inc;
			ST_DY_WAIT: if (div_stat.done) inc_y_q <= div_inc;
			ST_PMX: num_x_q <= NW'(prod);
			ST_PMY: num_y_q <= NW'(prod);
			ST_PX_WAIT: begin
				if (div_stat.done) begin
					px_q <= div_pix;
					num_x_q <= num_x_q + NW'(dx_q);
				end
			end
			ST_PY_WAIT: begin
				if (div_stat.done) begin
					py_q <= div_pix;
					num_y_q <= num_y_q + NW'(dy_q);
				end
			end
			default: ;
		endcase

		// output register
		if (emit) begin
			out_q.px <= px_q;
			out_q.py <= py_q;
			out_q.colour <= colour_q;
			out_q.last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix = out_q;

`ifndef NO_ASSERTIONS
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy) else $error("divider started while busy");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DX_WAIT || state_q == ST_DY_WAIT ||
			state_q == ST_PX_WAIT || state_q == ST_PY_WAIT))
		else $error("divider result outside a wait state");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending pixel overwritten");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE)) else $error("command taken while busy");
`endif

endmodule
`default_nettype wire
